### rtl/magnetometer_calibrated_heading_assert.svh
// assertion macros for the calibrated heading block
`ifndef MAGNETOMETER_CALIBRATED_HEADING_ASSERT_SVH
`define MAGNETOMETER_CALIBRATED_HEADING_ASSERT_SVH

// clocked property with asynchronous reset disable
`define MCH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked even while reset is low
`define MCH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mch_pkg.sv
// shared constants and tables for the calibrated heading block
package mch_pkg;

    // default parameter values
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ANGLE_STAGES_DEF = 16;
    localparam int ANGLE_TAB_LEN    = 24;

    // angle constants
    localparam int FULL_TURN        = 36000;
    localparam int HALF_TURN_SCALED = 4608000;
    localparam int ANGLE_W          = 25;

    // configuration port layout
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_BIAS_X   = 3'd0;
    localparam logic [2:0] REG_BIAS_Y   = 3'd1;
    localparam logic [2:0] REG_BIAS_Z   = 3'd2;
    localparam logic [2:0] REG_ROW_X    = 3'd3;
    localparam logic [2:0] REG_ROW_Y    = 3'd4;
    localparam logic [2:0] REG_ROW_Z    = 3'd5;
    localparam logic [2:0] REG_OFFSET   = 3'd6;

    localparam logic [47:0] ROW_X_RESET  = 48'd16384;
    localparam logic [47:0] ROW_Y_RESET  = 48'd1073741824;
    localparam logic [47:0] ROW_Z_RESET  = 48'd70368744177664;
    localparam logic [15:0] OFFSET_RESET = 16'd9000;

    // atan(2^-i) in units of 1/256 centidegree
    localparam logic [ANGLE_W-1:0] ATAN_TAB [ANGLE_TAB_LEN] = '{
        25'd1152000, 25'd680065, 25'd359328, 25'd182400,
        25'd91554,   25'd45822,  25'd22916,  25'd11459,
        25'd5730,    25'd2865,   25'd1432,   25'd716,
        25'd358,     25'd179,    25'd90,     25'd45,
        25'd22,      25'd11,     25'd6,      25'd3,
        25'd1,       25'd1,      25'd0,      25'd0
    };

endpackage

### rtl/mch_if.sv
// sample and result channel interfaces
interface mch_in_if #(
    parameter int W = mch_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] mag_x;
    logic signed [W-1:0] mag_y;
    logic signed [W-1:0] mag_z;

    modport source (output valid, mag_x, mag_y, mag_z, input ready);
    modport sink   (input valid, mag_x, mag_y, mag_z, output ready);
endinterface

interface mch_out_if #(
    parameter int W = mch_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                valid;
    logic                ready;
    logic [15:0]         heading_centideg;
    logic signed [W-1:0] cal_x;
    logic signed [W-1:0] cal_y;
    logic signed [W-1:0] cal_z;

    modport source (output valid, heading_centideg, cal_x, cal_y, cal_z, input ready);
    modport sink   (input valid, heading_centideg, cal_x, cal_y, cal_z, output ready);
endinterface

### rtl/magnetometer_calibrated_heading.sv
// calibrated magnetometer heading pipeline with register port
// Usage:
//   sample (valid/ready): one raw magnetometer word mag_x/y/z per handshake.
//   result (valid/ready): one word per sample with heading_centideg and
//   the calibrated cal_x/y/z, in input order.
//   APB-style port: seven registers at byte address 8*i (bias x/y/z,
//   matrix rows x/y/z, heading offset); write only while the pipe is empty.
// Throughput: one word per cycle while the result is not held,
//   set by the pipeline of bias subtract, multiply, row sum, CORDIC prep,
//   ANGLE_STAGES CORDIC stages, rounding and wrap, one register each.
// Reset: all valid bits clear, registers take their reset values
//   (unit matrix, zero bias, 9000 offset); no clearing pass.
// Stall: when the result is held, the whole pipeline freezes and
//   sample.ready drops; no word is lost or repeated.
module magnetometer_calibrated_heading #(
    parameter int SAMPLE_WIDTH = mch_pkg::SAMPLE_WIDTH_DEF,
    parameter int ANGLE_STAGES = mch_pkg::ANGLE_STAGES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mch_in_if.sink                     sample,
    mch_out_if.source                  result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mch_pkg::ADDR_W-1:0] paddr,
    input  logic [mch_pkg::DATA_W-1:0] pwdata,
    output logic [mch_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int L    = ANGLE_STAGES;
    localparam int DW   = ((SW > 16) ? SW : 16) + 1;
    localparam int PW   = DW + 16;
    localparam int SUMW = PW + 2;
    localparam int CW   = SW + 12;
    localparam int AW   = mch_pkg::ANGLE_W;
    localparam int RW   = AW - 8;
    localparam int LAST = L + 5;

    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

    // configuration registers
    logic [15:0] bias_reg [3];
    logic [47:0] row_reg  [3];
    logic [15:0] offset_reg;
    logic        wr_en;
    logic [2:0]  wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg[0] <= '0;
            bias_reg[1] <= '0;
            bias_reg[2] <= '0;
            row_reg[0]  <= mch_pkg::ROW_X_RESET;
            row_reg[1]  <= mch_pkg::ROW_Y_RESET;
            row_reg[2]  <= mch_pkg::ROW_Z_RESET;
            offset_reg  <= mch_pkg::OFFSET_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                mch_pkg::REG_BIAS_X: bias_reg[0] <= pwdata[15:0];
                mch_pkg::REG_BIAS_Y: bias_reg[1] <= pwdata[15:0];
                mch_pkg::REG_BIAS_Z: bias_reg[2] <= pwdata[15:0];
                mch_pkg::REG_ROW_X:  row_reg[0]  <= pwdata[47:0];
                mch_pkg::REG_ROW_Y:  row_reg[1]  <= pwdata[47:0];
                mch_pkg::REG_ROW_Z:  row_reg[2]  <= pwdata[47:0];
                mch_pkg::REG_OFFSET: offset_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        unique case (wr_idx)
            mch_pkg::REG_BIAS_X: prdata = {48'd0, bias_reg[0]};
            mch_pkg::REG_BIAS_Y: prdata = {48'd0, bias_reg[1]};
            mch_pkg::REG_BIAS_Z: prdata = {48'd0, bias_reg[2]};
            mch_pkg::REG_ROW_X:  prdata = {16'd0, row_reg[0]};
            mch_pkg::REG_ROW_Y:  prdata = {16'd0, row_reg[1]};
            mch_pkg::REG_ROW_Z:  prdata = {16'd0, row_reg[2]};
            mch_pkg::REG_OFFSET: prdata = {48'd0, offset_reg};
            default:             prdata = '0;
        endcase
    end

    // global advance: move when the output slot is free or taken
    logic en;
    logic vld_reg [0:LAST];

    assign en           = !vld_reg[LAST] || result.ready;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= sample.valid;
            for (int i = 1; i <= LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage 0: bias subtract
    logic signed [DW-1:0] d_reg [3];
    logic signed [SW-1:0] mag [3];

    assign mag[0] = sample.mag_x;
    assign mag[1] = sample.mag_y;
    assign mag[2] = sample.mag_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                d_reg[c] <= DW'(mag[c]) - DW'(signed'(bias_reg[c]));
            end
        end
    end

    // stage 1: nine coefficient products
    logic signed [PW-1:0] p_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    p_reg[r][c] <= PW'(signed'(row_reg[r][16*c +: 16])) * PW'(d_reg[c]);
                end
            end
        end
    end

    // stage 2: row sums, round half up, saturate
    logic signed [SW-1:0]   cal_reg [2:LAST][3];
    logic signed [SUMW-1:0] sum_next [3];
    logic signed [SUMW-1:0] sh_next  [3];
    logic signed [SW-1:0]   cal_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = SUMW'(p_reg[r][0]) + SUMW'(p_reg[r][1]) + SUMW'(p_reg[r][2])
                        + SUMW'(8192);
            sh_next[r]  = sum_next[r] >>> 14;
            if (sh_next[r] > SAT_HI)
                cal_next[r] = SAT_HI[SW-1:0];
            else if (sh_next[r] < SAT_LO)
                cal_next[r] = SAT_LO[SW-1:0];
            else
                cal_next[r] = sh_next[r][SW-1:0];
        end
    end

    // calibrated components ride along to the output
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cal_reg[2] <= cal_next;
            for (int s = 3; s <= LAST; s++)
            begin
                cal_reg[s] <= cal_reg[s-1];
            end
        end
    end

    // stage 3: CORDIC prep, fold left half plane, scale by 256
    logic signed [CW-1:0] x_reg   [3:3+L];
    logic signed [CW-1:0] y_reg   [3:3+L];
    logic signed [AW-1:0] ang_reg [3:3+L];
    logic                 zero_reg [3:3+L];
    logic signed [CW-1:0] xe_next;
    logic signed [CW-1:0] ye_next;
    logic                 neg_next;

    assign xe_next  = CW'(cal_reg[2][0]);
    assign ye_next  = CW'(cal_reg[2][1]);
    assign neg_next = cal_reg[2][0] < 0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[3] <= (cal_reg[2][0] == '0) && (cal_reg[2][1] == '0);
            x_reg[3]    <= (neg_next ? -xe_next : xe_next) <<< 8;
            y_reg[3]    <= (neg_next ? -ye_next : ye_next) <<< 8;
            ang_reg[3]  <= neg_next ? AW'(mch_pkg::HALF_TURN_SCALED) : '0;
        end
    end

    // CORDIC vectoring stages, one per register
    for (genvar k = 0; k < L; k++)
    begin : g_cordic
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;

        assign xs = x_reg[3+k] >>> k;
        assign ys = y_reg[3+k] >>> k;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[4+k] <= zero_reg[3+k];
                if (y_reg[3+k] >= 0)
                begin
                    x_reg[4+k]   <= x_reg[3+k] + ys;
                    y_reg[4+k]   <= y_reg[3+k] - xs;
                    ang_reg[4+k] <= ang_reg[3+k] + signed'(mch_pkg::ATAN_TAB[k]);
                end
                else
                begin
                    x_reg[4+k]   <= x_reg[3+k] - ys;
                    y_reg[4+k]   <= y_reg[3+k] + xs;
                    ang_reg[4+k] <= ang_reg[3+k] - signed'(mch_pkg::ATAN_TAB[k]);
                end
            end
        end
    end

    // stage L+4: round angle, fold offset into one turn
    logic signed [RW-1:0] raw_reg;
    logic [15:0]          offm_reg;
    logic signed [AW-1:0] rnd_next;

    assign rnd_next = (ang_reg[3+L] + AW'(128)) >>> 8;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg  <= zero_reg[3+L] ? '0 : rnd_next[RW-1:0];
            offm_reg <= (offset_reg >= 16'(mch_pkg::FULL_TURN))
                      ? offset_reg - 16'(mch_pkg::FULL_TURN) : offset_reg;
        end
    end

    // stage L+5: subtract offset and wrap into 0..35999
    logic [15:0]          heading_reg;
    logic signed [18:0]   h0_next;
    logic signed [18:0]   h_next;

    always_comb
    begin
        h0_next = 19'(raw_reg) - signed'({3'd0, offm_reg});
        h_next  = h0_next;
        if (h0_next < 0)
            h_next = h0_next + 19'(mch_pkg::FULL_TURN);
        if (h_next < 0)
            h_next = h_next + 19'(mch_pkg::FULL_TURN);
        else if (h_next >= 19'(mch_pkg::FULL_TURN))
            h_next = h_next - 19'(mch_pkg::FULL_TURN);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            heading_reg <= h_next[15:0];
        end
    end

    // result word
    assign result.valid            = vld_reg[LAST];
    assign result.heading_centideg = heading_reg;
    assign result.cal_x            = cal_reg[LAST][0];
    assign result.cal_y            = cal_reg[LAST][1];
    assign result.cal_z            = cal_reg[LAST][2];

endmodule

### rtl/mch_checker.sv
// port-level checks for the calibrated heading block, bound to the top level
`include "magnetometer_calibrated_heading_assert.svh"

module mch_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] heading
);

    // a held result word stays valid
    `MCH_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    // heading always lies inside one turn
    `MCH_ASSERT(a_heading_range, clk, rst_n, out_valid |-> heading < 16'd36000, "heading out of range")

    // an empty output slot never blocks the input
    `MCH_ASSERT(a_ready_free, clk, rst_n, !out_valid |-> in_ready, "input blocked with empty output")

    // a taken result always frees the input
    `MCH_ASSERT(a_ready_drain, clk, rst_n, out_ready |-> in_ready, "input blocked while output drains")

    // no result appears right after reset
    `MCH_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind magnetometer_calibrated_heading mch_checker u_mch_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .heading   (result.heading_centideg)
);

### tb/sv/tb_magnetometer_calibrated_heading.sv
// testbench for the calibrated magnetometer heading pipeline
module tb_magnetometer_calibrated_heading;

    localparam int LATENCY = 21;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } mag_word_t;

    typedef struct packed {
        logic [15:0]        heading;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
    } heading_word_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [mch_pkg::ADDR_W-1:0] paddr;
    logic [mch_pkg::DATA_W-1:0] pwdata;
    logic [mch_pkg::DATA_W-1:0] prdata;
    logic pready;

    mch_in_if  sample_ch ();
    mch_out_if result_ch ();

    magnetometer_calibrated_heading u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch.sink),
        .result  (result_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the calibration registers
    logic signed [15:0] cal_bias [3];
    logic [47:0]        cal_row [3];
    logic [15:0]        cal_offset;

    mag_word_t     pending_words [$];
    heading_word_t expected_words [$];
    int            error_count;
    int            accepted_count;
    int            result_count;
    int            idle_cycles;
    logic          drive_enable;
    logic          hold_sender;
    logic          in_fire = 1'b0;
    int            burst_left;
    int            gap_left;
    int            stall_phase;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor division by a power of two
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint calibrate_row(logic [47:0] row, longint dx, longint dy,
                                             longint dz);
        longint acc;
        acc = longint'($signed(row[15:0])) * dx + longint'($signed(row[31:16])) * dy
            + longint'($signed(row[47:32])) * dz;
        return clamp16(floor_shift(acc + 8192, 14));
    endfunction

    // cordic angle of (x, y) in centidegrees
    function automatic longint cordic_angle(longint y, longint x);
        longint angle;
        longint xs;
        longint ys;
        angle = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            angle = mch_pkg::HALF_TURN_SCALED;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < 16; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                angle = angle + longint'(mch_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                angle = angle - longint'(mch_pkg::ATAN_TAB[i]);
            end
        end
        return floor_shift(angle + 128, 8);
    endfunction

    function automatic heading_word_t predict_heading(mag_word_t w);
        heading_word_t r;
        longint dx;
        longint dy;
        longint dz;
        longint cx;
        longint cy;
        longint cz;
        longint h;
        dx = longint'(w.x) - longint'(cal_bias[0]);
        dy = longint'(w.y) - longint'(cal_bias[1]);
        dz = longint'(w.z) - longint'(cal_bias[2]);
        cx = calibrate_row(cal_row[0], dx, dy, dz);
        cy = calibrate_row(cal_row[1], dx, dy, dz);
        cz = calibrate_row(cal_row[2], dx, dy, dz);
        h = (cordic_angle(cy, cx) - longint'(cal_offset)) % mch_pkg::FULL_TURN;
        if (h < 0)
            h = h + mch_pkg::FULL_TURN;
        r.heading = h[15:0];
        r.cx = cx[15:0];
        r.cy = cy[15:0];
        r.cz = cz[15:0];
        return r;
    endfunction

    // register write over the apb port, updates the shadow copy and reads back
    task automatic write_reg(logic [2:0] index, logic [63:0] value);
        logic [63:0] rd_want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mch_pkg::ADDR_W'(index) << 3;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rd_want = '0;
        case (index)
            mch_pkg::REG_BIAS_X:
            begin
                cal_bias[0] = value[15:0];
                rd_want = {48'd0, value[15:0]};
            end
            mch_pkg::REG_BIAS_Y:
            begin
                cal_bias[1] = value[15:0];
                rd_want = {48'd0, value[15:0]};
            end
            mch_pkg::REG_BIAS_Z:
            begin
                cal_bias[2] = value[15:0];
                rd_want = {48'd0, value[15:0]};
            end
            mch_pkg::REG_ROW_X:
            begin
                cal_row[0] = value[47:0];
                rd_want = {16'd0, value[47:0]};
            end
            mch_pkg::REG_ROW_Y:
            begin
                cal_row[1] = value[47:0];
                rd_want = {16'd0, value[47:0]};
            end
            mch_pkg::REG_ROW_Z:
            begin
                cal_row[2] = value[47:0];
                rd_want = {16'd0, value[47:0]};
            end
            mch_pkg::REG_OFFSET:
            begin
                cal_offset = value[15:0];
                rd_want = {48'd0, value[15:0]};
            end
            default: ;
        endcase
        // register read back
        if (prdata !== rd_want)
        begin
            $error("prdata expected %0h actual %0h", rd_want, prdata);
            error_count = error_count + 1;
        end
    endtask

    function automatic logic [15:0] coeff_random();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'd0;
            3: return 16'd16384;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // three coefficients, random bits above the row
    function automatic logic [63:0] row_random();
        return {16'($urandom()), coeff_random(), coeff_random(), coeff_random()};
    endfunction

    function automatic mag_word_t random_word();
        mag_word_t w;
        w = mag_word_t'({16'($urandom()), $urandom()});
        if ($urandom_range(0, 3) == 0)
            w.z = '0;
        if ($urandom_range(0, 7) == 0)
        begin
            w.x = cal_bias[0];
            w.y = cal_bias[1];
        end
        if ($urandom_range(0, 7) == 0)
            w.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return w;
    endfunction

    // wait for the pipe to drain, plus latency margin
    task automatic drain_pipe();
        while (pending_words.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // sender: bursts and gaps, optional hold
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
        end
        else if (!sample_ch.valid || in_fire)
        begin
            if (drive_enable && !hold_sender && pending_words.size() != 0
                && gap_left == 0)
            begin
                sample_ch.valid <= 1'b1;
                sample_ch.mag_x <= pending_words[0].x;
                sample_ch.mag_y <= pending_words[0].y;
                sample_ch.mag_z <= pending_words[0].z;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left = burst_left - 1;
            end
            else
            begin
                sample_ch.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left = gap_left - 1;
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        stall_phase = stall_phase + 1;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (stall_phase % 512 < 128)
            result_ch.ready <= 1'b1;
        else
            result_ch.ready <= ($urandom_range(0, 99) < ((stall_phase / 512) % 2 ? 30 : 80));
    end

    // accept words, predict, check results
    always @(posedge clk)
    begin
        heading_word_t got;
        heading_word_t want;
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            in_fire = sample_ch.valid && sample_ch.ready;
            if (in_fire)
            begin
                expected_words.push_back(predict_heading(pending_words.pop_front()));
                accepted_count = accepted_count + 1;
                idle_cycles = 0;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                idle_cycles = 0;
                result_count = result_count + 1;
                got.heading = result_ch.heading_centideg;
                got.cx = result_ch.cal_x;
                got.cy = result_ch.cal_y;
                got.cz = result_ch.cal_z;
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    error_count = error_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.heading !== want.heading)
                    begin
                        $error("heading_centideg expected %0d actual %0d", want.heading,
                               got.heading);
                        error_count = error_count + 1;
                    end
                    if (got.cx !== want.cx)
                    begin
                        $error("cal_x expected %0d actual %0d", want.cx, got.cx);
                        error_count = error_count + 1;
                    end
                    if (got.cy !== want.cy)
                    begin
                        $error("cal_y expected %0d actual %0d", want.cy, got.cy);
                        error_count = error_count + 1;
                    end
                    if (got.cz !== want.cz)
                    begin
                        $error("cal_z expected %0d actual %0d", want.cz, got.cz);
                        error_count = error_count + 1;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("magnetometer_calibrated_heading verification failed");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        mag_word_t w;
        logic [15:0] offsets [4];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        drive_enable = 1'b0;
        hold_sender = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        error_count = 0;
        accepted_count = 0;
        result_count = 0;
        idle_cycles = 0;
        cal_bias[0] = 0;
        cal_bias[1] = 0;
        cal_bias[2] = 0;
        cal_row[0] = mch_pkg::ROW_X_RESET;
        cal_row[1] = mch_pkg::ROW_Y_RESET;
        cal_row[2] = mch_pkg::ROW_Z_RESET;
        cal_offset = mch_pkg::OFFSET_RESET;
        offsets[0] = 16'd0;
        offsets[1] = 16'd35999;
        offsets[2] = 16'd36000;
        offsets[3] = 16'hffff;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words at reset settings: extremes, zero vector, axes
        pending_words.push_back('{16'sd0, 16'sd0, 16'sd0});
        pending_words.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        pending_words.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        pending_words.push_back('{16'sh7fff, 16'sh8000, 16'sd1});
        pending_words.push_back('{16'sh8000, 16'sh7fff, -16'sd1});
        pending_words.push_back('{16'sd100, 16'sd0, 16'sd0});
        pending_words.push_back('{-16'sd100, 16'sd0, 16'sd0});
        pending_words.push_back('{16'sd0, 16'sd100, 16'sd0});
        pending_words.push_back('{16'sd0, -16'sd100, 16'sd0});
        pending_words.push_back('{-16'sd5, -16'sd1, 16'sd0});
        pending_words.push_back('{16'shaaaa, 16'sh5555, 16'shffff});
        drive_enable = 1'b1;
        drain_pipe();

        // extreme settings, a write past the register map, then random and extreme words
        write_reg(mch_pkg::REG_BIAS_X, 64'hffff_ffff_ffff_8000);
        write_reg(mch_pkg::REG_BIAS_Y, 64'h0000_0000_0000_7fff);
        write_reg(mch_pkg::REG_BIAS_Z, 64'h8000);
        write_reg(mch_pkg::REG_ROW_X, 64'hffff_7fff_7fff_7fff);
        write_reg(mch_pkg::REG_ROW_Y, 64'h0000_8000_8000_8000);
        write_reg(mch_pkg::REG_ROW_Z, 64'h0000_7fff_8000_0000);
        write_reg(mch_pkg::REG_OFFSET, 64'h1_ffff);
        write_reg(REG_UNMAPPED, 64'h1234);
        for (int i = 0; i < 8; i++)
            pending_words.push_back(random_word());
        pending_words.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff});
        pending_words.push_back('{16'sh8000, 16'sh7fff, 16'sh8000});
        drain_pipe();

        // random phases under varied settings
        for (int phase = 0; phase < 10; phase++)
        begin
            write_reg(mch_pkg::REG_BIAS_X, {$urandom(), $urandom()});
            write_reg(mch_pkg::REG_BIAS_Y, {$urandom(), $urandom()});
            write_reg(mch_pkg::REG_BIAS_Z,
                      $urandom_range(0, 1) ? 64'd0 : {$urandom(), $urandom()});
            write_reg(mch_pkg::REG_ROW_X, row_random());
            write_reg(mch_pkg::REG_ROW_Y, row_random());
            write_reg(mch_pkg::REG_ROW_Z, row_random());
            write_reg(mch_pkg::REG_OFFSET, phase < 4 ? {48'd0, offsets[phase]} :
                      64'($urandom_range(0, 65535)));
            for (int i = 0; i < 60; i++)
            begin
                w = random_word();
                pending_words.push_back(w);
                if (i == 30 && phase == 3)
                begin
                    // hold the sender until the pipe is empty
                    while (pending_words.size() != 0)
                        @(posedge clk);
                    hold_sender = 1'b1;
                    while (expected_words.size() != 0)
                        @(posedge clk);
                    hold_sender = 1'b0;
                end
            end
            drain_pipe();
        end

        $display("covered %0d sample words and %0d result words", accepted_count,
                 result_count);
        $display("settings included extreme biases, coefficients and offsets");
        if (error_count == 0 && expected_words.size() == 0)
            $display("magnetometer_calibrated_heading verification clean");
        else
            $display("magnetometer_calibrated_heading verification failed");
        $finish;
    end
endmodule
